// ===== hdl/fixed_point_alu_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion forms used by the ALU RTL.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FPA_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FPA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes, status codes and default sizes for the ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  // Default number of fraction bits in a raw word.
  localparam int FRAC_BITS_DEFAULT = 8;

  // Saturation range is the signed range of this many bits.
  localparam int WORD_BITS = 32;

  // Operands are wrapped to this many bits before use.
  localparam int OPND_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;

  // Operation codes.
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_SUB     = 4'd1;
  localparam logic [3:0] OP_MUL     = 4'd2;
  localparam logic [3:0] OP_DIV     = 4'd3;
  localparam logic [3:0] OP_GT      = 4'd4;
  localparam logic [3:0] OP_LT      = 4'd5;
  localparam logic [3:0] OP_GE      = 4'd6;
  localparam logic [3:0] OP_LE      = 4'd7;
  localparam logic [3:0] OP_EQ      = 4'd8;
  localparam logic [3:0] OP_NE      = 4'd9;
  localparam logic [3:0] OP_INC     = 4'd10;
  localparam logic [3:0] OP_DEC     = 4'd11;
  localparam logic [3:0] OP_MIN     = 4'd12;
  localparam logic [3:0] OP_MAX     = 4'd13;
  localparam logic [3:0] OP_TOINT   = 4'd14;
  localparam logic [3:0] OP_FROMINT = 4'd15;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU unit
// Pipelined signed fixed-point ALU with saturation, rounded multiply and a
// one-bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_*       in         operation code (tuser) and two raw operands (tdata)
//  m_*       out        raw result (tdata), compare flag and status (tuser)
//
//  Every operation passes through every stage; one transaction can enter in
//  every cycle while s_tready is high. The depth is set by the divider, which
//  retires one quotient bit per pipeline stage (32 + FRAC_BITS stages).
//  Reset clears only the stage valid bits. A stall at the output holds the
//  last stage; earlier stages keep moving into empty slots behind it.
//
`default_nettype none

`include "fixed_point_alu_unit_macros.svh"

module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  wire logic [3:0]  s_tuser,   // [3:0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] result
  output logic [2:0]       m_tuser    // [0] compare_true, [2:1] status
);

  localparam int QB  = 32 + FRAC_BITS;   // quotient bits
  localparam int NST = QB + 3;           // pipeline stages
  localparam int OW  = fpa_pkg::OPND_BITS;

  localparam logic signed [65:0] WMAX =
    (66'sd1 <<< (fpa_pkg::WORD_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] WMIN = -WMAX - 66'sd1;
  localparam logic [64:0] HALF = 65'd1 << (FRAC_BITS - 1);

  typedef struct packed {
    logic [3:0]    kind;
    logic          neg;
    logic          flag;
    logic [1:0]    status;
    logic [31:0]   res;
    logic [63:0]   prod;
    logic [QB:0]   quo;
    logic [32:0]   rem;
    logic [QB-1:0] num;
    logic [31:0]   den;
  } stage_t;

  stage_t st [NST];
  stage_t st_next [NST];
  logic   valid [NST];
  logic   rdy [NST+1];

  // Saturate a wide value to the word range; top bit flags overflow.
  function automatic logic [32:0] sat_word(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > WMAX) begin
      r = {1'b1, WMAX[31:0]};
    end else if (v < WMIN) begin
      r = {1'b1, WMIN[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Input decode.
  logic signed [32:0] a33, b33;
  logic signed [65:0] a66, b66, s_add, s_sub, s_inc, s_dec, s_fi;
  logic [32:0]        mag_a, mag_b, sat_r;
  stage_t             d0;

  always_comb begin
    a33   = signed'({{(33 - OW){s_tdata[OW-1]}}, s_tdata[OW-1:0]});
    b33   = signed'({{(33 - OW){s_tdata[32+OW-1]}}, s_tdata[32+OW-1:32]});
    a66   = 66'(a33);
    b66   = 66'(b33);
    s_add = a66 + b66;
    s_sub = a66 - b66;
    s_inc = a66 + 66'sd1;
    s_dec = a66 - 66'sd1;
    s_fi  = a66 <<< FRAC_BITS;
    mag_a = a33[32] ? 33'(-a33) : 33'(a33);
    mag_b = b33[32] ? 33'(-b33) : 33'(b33);
    sat_r = 33'd0;
    d0        = '0;
    d0.kind   = s_tuser;
    d0.neg    = a33[32] ^ b33[32];
    d0.status = fpa_pkg::ST_OK;
    d0.num    = {mag_a[31:0], {FRAC_BITS{1'b0}}};
    d0.den    = mag_b[31:0];
    case (s_tuser)
      fpa_pkg::OP_ADD:     sat_r = sat_word(s_add);
      fpa_pkg::OP_SUB:     sat_r = sat_word(s_sub);
      fpa_pkg::OP_INC:     sat_r = sat_word(s_inc);
      fpa_pkg::OP_DEC:     sat_r = sat_word(s_dec);
      fpa_pkg::OP_FROMINT: sat_r = sat_word(s_fi);
      fpa_pkg::OP_GT:      d0.flag = a33 > b33;
      fpa_pkg::OP_LT:      d0.flag = a33 < b33;
      fpa_pkg::OP_GE:      d0.flag = a33 >= b33;
      fpa_pkg::OP_LE:      d0.flag = a33 <= b33;
      fpa_pkg::OP_EQ:      d0.flag = a33 == b33;
      fpa_pkg::OP_NE:      d0.flag = a33 != b33;
      fpa_pkg::OP_MIN:     sat_r = {1'b0, (a33 < b33) ? a33[31:0] : b33[31:0]};
      fpa_pkg::OP_MAX:     sat_r = {1'b0, (a33 > b33) ? a33[31:0] : b33[31:0]};
      fpa_pkg::OP_TOINT:   sat_r = {1'b0, 32'(a33 >>> FRAC_BITS)};
      fpa_pkg::OP_DIV: begin
        if (b33 == 33'sd0) begin
          d0.status = fpa_pkg::ST_DIV0;
        end
      end
      default: sat_r = 33'd0;
    endcase
    d0.res = sat_r[31:0];
    if (sat_r[32]) begin
      d0.status = fpa_pkg::ST_SAT;
    end
  end

  // Per-stage work: multiply, divider steps, quotient rounding, final sign.
  logic [32:0]        dv_r2 [NST];
  logic [64:0]        mq    [NST];
  logic signed [65:0] sv    [NST];
  logic [32:0]        fs    [NST];

  always_comb begin
    for (int i = 0; i < NST; i++) begin
      dv_r2[i] = '0;
      mq[i]    = '0;
      sv[i]    = '0;
      fs[i]    = '0;
      if (i == 0) begin
        st_next[i] = d0;
      end else begin
        st_next[i] = st[i-1];
        if (i == 1) begin
          st_next[i].prod = st[i-1].num[QB-1:FRAC_BITS] * st[i-1].den;
        end
        if (i == 2 && st[i-1].kind == fpa_pkg::OP_MUL) begin
          mq[i] = (65'(st[i-1].prod) + HALF) >> FRAC_BITS;
          sv[i] = st[i-1].neg ? -signed'(66'(mq[i])) : signed'(66'(mq[i]));
          fs[i] = sat_word(sv[i]);
          st_next[i].res = fs[i][31:0];
          if (fs[i][32]) begin
            st_next[i].status = fpa_pkg::ST_SAT;
          end
        end
        if (i <= QB) begin
          dv_r2[i] = {st[i-1].rem[31:0], st[i-1].num[QB-1]};
          st_next[i].num = st[i-1].num << 1;
          if (dv_r2[i] >= {1'b0, st[i-1].den}) begin
            st_next[i].rem = dv_r2[i] - {1'b0, st[i-1].den};
            st_next[i].quo = {st[i-1].quo[QB-1:0], 1'b1};
          end else begin
            st_next[i].rem = dv_r2[i];
            st_next[i].quo = {st[i-1].quo[QB-1:0], 1'b0};
          end
        end
        if (i == QB + 1) begin
          if ({st[i-1].rem[31:0], 1'b0} >= {1'b0, st[i-1].den}) begin
            st_next[i].quo = st[i-1].quo + (QB+1)'(1);
          end
        end
        if (i == QB + 2 && st[i-1].kind == fpa_pkg::OP_DIV &&
            st[i-1].status != fpa_pkg::ST_DIV0) begin
          sv[i] = st[i-1].neg ? -signed'(66'(st[i-1].quo)) : signed'(66'(st[i-1].quo));
          fs[i] = sat_word(sv[i]);
          st_next[i].res = fs[i][31:0];
          if (fs[i][32]) begin
            st_next[i].status = fpa_pkg::ST_SAT;
          end
        end
      end
    end
  end

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    rdy[NST] = m_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !valid[i] || rdy[i+1];
    end
  end

  // Stage registers; valid bits reset, payload does not.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (rdy[i]) begin
        st[i] <= st_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) begin
        valid[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) begin
          valid[i] <= (i == 0) ? s_tvalid : valid[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // Ports.
  assign s_tready = rdy[0];
  assign m_tvalid = valid[NST-1];
  assign m_tdata  = st[NST-1].res;
  assign m_tuser  = {st[NST-1].status, st[NST-1].flag};

  // Assertions.
  `FPA_ASSERT_NOW(a_status_code, clk, rst, m_tvalid, m_tuser[2:1] != 2'd3,
    "Result carries an undefined status code.")
  `FPA_ASSERT_NOW(a_flag_zero, clk, rst, m_tvalid && m_tuser[0],
    m_tdata == 32'd0 && m_tuser[2:1] == fpa_pkg::ST_OK,
    "Comparison result must have zero result and ok status.")
  `FPA_ASSERT_NOW(a_div0_zero, clk, rst, m_tvalid && m_tuser[2:1] == fpa_pkg::ST_DIV0,
    m_tdata == 32'd0 && !m_tuser[0],
    "Divide by zero must give a zero result.")
  `FPA_ASSERT_NEXT(a_out_hold, clk, rst, valid[NST-1] && !m_tready,
    valid[NST-1] && $stable(st[NST-1]),
    "Last stage lost its transaction during a stall.")

endmodule

`default_nettype wire
